// ----- hdl/drls_pkg.sv -----
// drls_pkg: shared constants, register indexes and the stage payload type
// for the disc rim shader; no dependencies
package drls_pkg;

  localparam int COORD_BITS_DEF = 12;
  localparam int COORD_BITS_MAX = 16;
  localparam int RADIUS_W       = 10;
  localparam int LEVEL_W        = 8;
  localparam int CFG_IDX_W      = 3;

  // reset values of the configuration registers
  localparam int DISC_CENTER_X_RST = 450;
  localparam int DISC_CENTER_Y_RST = 300;
  localparam int DISC_RADIUS_RST   = 50;
  localparam int LIGHT_X_RST       = 720;
  localparam int LIGHT_Y_RST       = 300;

  // 255 squared, scale of the squared level compare
  localparam int LEVEL_SCALE = 65025;

  // payload widths, sized for the widest coordinate setting
  localparam int R2_W   = 2 * RADIUS_W;
  localparam int L2_W   = 2 * COORD_BITS_MAX + 1;
  localparam int DEN_W  = R2_W + L2_W;
  localparam int NUM_W  = (DEN_W + 1) / 2;
  localparam int CMP_W  = DEN_W + 2 * LEVEL_W;
  localparam int BDEN_W = DEN_W + LEVEL_W;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DISC_CENTER_X = 3'd0,
    REG_DISC_CENTER_Y = 3'd1,
    REG_DISC_RADIUS   = 3'd2,
    REG_LIGHT_X       = 3'd3,
    REG_LIGHT_Y       = 3'd4
  } reg_idx_e;

  // data handed from one level cell to the next
  typedef struct packed {
    logic               covered;
    logic               rim;
    logic               go;
    logic [DEN_W-1:0]   den;
    logic [CMP_W-1:0]   k;
    logic [LEVEL_W-1:0] b;
    logic [BDEN_W-1:0]  bden;
    logic [CMP_W-1:0]   b2den;
  } shade_t;

  function automatic int cfg_data_w(int cb);
    return (cb > RADIUS_W) ? cb : RADIUS_W;
  endfunction

endpackage

// ----- hdl/drls_if.sv -----
// drls_in_if / drls_out_if: valid-ready channels for pixel requests and
// shading results; no dependencies
interface drls_in_if #(
  parameter int COORD_BITS = 12
);
  logic                  valid;
  logic                  ready;
  logic signed [COORD_BITS:0] pixel_x;
  logic signed [COORD_BITS:0] pixel_y;

  modport source (output valid, pixel_x, pixel_y, input ready);
  modport sink   (input valid, pixel_x, pixel_y, output ready);
endinterface

interface drls_out_if;
  logic       valid;
  logic       ready;
  logic       covered;
  logic       on_rim;
  logic [7:0] brightness;

  modport source (output valid, covered, on_rim, brightness, input ready);
  modport sink   (input valid, covered, on_rim, brightness, output ready);
endinterface

// ----- hdl/drls_front.sv -----
// drls_front: configuration registers and the three geometry stages
// (squares and dot product, coverage and products, compare scale); uses drls_pkg
module drls_front #(
  parameter int COORD_BITS = drls_pkg::COORD_BITS_DEF
) (
  input  logic                                        clk_i,
  input  logic                                        rst_ni,
  input  logic                                        cfg_we_i,
  input  logic [drls_pkg::CFG_IDX_W-1:0]              cfg_idx_i,
  input  logic [drls_pkg::cfg_data_w(COORD_BITS)-1:0] cfg_data_i,
  input  logic                                        in_valid_i,
  output logic                                        in_ready_o,
  input  logic signed [COORD_BITS:0]                  pixel_x_i,
  input  logic signed [COORD_BITS:0]                  pixel_y_i,
  output logic                                        out_valid_o,
  input  logic                                        out_ready_i,
  output drls_pkg::shade_t                            out_o
);

  localparam int DW   = COORD_BITS + 2;
  localparam int LW   = COORD_BITS + 1;
  localparam int D2W  = 2 * COORD_BITS + 3;
  localparam int DOTW = 2 * COORD_BITS + 4;
  localparam int L2W  = 2 * COORD_BITS + 1;
  localparam int RW   = drls_pkg::RADIUS_W;
  // width of the coverage and rim band compares
  localparam int SW   = ((D2W > drls_pkg::R2_W) ? D2W : drls_pkg::R2_W) + 5;

  // configuration registers
  logic [COORD_BITS-1:0] cx_q, cy_q, lx_q, ly_q;
  logic [RW-1:0]         r_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cx_q <= COORD_BITS'(drls_pkg::DISC_CENTER_X_RST);
      cy_q <= COORD_BITS'(drls_pkg::DISC_CENTER_Y_RST);
      r_q  <= RW'(drls_pkg::DISC_RADIUS_RST);
      lx_q <= COORD_BITS'(drls_pkg::LIGHT_X_RST);
      ly_q <= COORD_BITS'(drls_pkg::LIGHT_Y_RST);
    end else if (cfg_we_i) begin
      unique case (drls_pkg::reg_idx_e'(cfg_idx_i))
        drls_pkg::REG_DISC_CENTER_X: cx_q <= cfg_data_i[COORD_BITS-1:0];
        drls_pkg::REG_DISC_CENTER_Y: cy_q <= cfg_data_i[COORD_BITS-1:0];
        drls_pkg::REG_DISC_RADIUS:   r_q  <= cfg_data_i[RW-1:0];
        drls_pkg::REG_LIGHT_X:       lx_q <= cfg_data_i[COORD_BITS-1:0];
        drls_pkg::REG_LIGHT_Y:       ly_q <= cfg_data_i[COORD_BITS-1:0];
        default: ;
      endcase
    end
  end

  // light vector and squared lengths derived from configuration
  logic signed [LW-1:0] vx_q, vy_q;
  logic [L2W-1:0]       l2_q;
  logic [drls_pkg::R2_W-1:0] r2_q;

  always_ff @(posedge clk_i) begin
    vx_q <= $signed({1'b0, cx_q}) - $signed({1'b0, lx_q});
    vy_q <= $signed({1'b0, cy_q}) - $signed({1'b0, ly_q});
    l2_q <= L2W'(vx_q * vx_q) + L2W'(vy_q * vy_q);
    r2_q <= drls_pkg::R2_W'(r_q) * drls_pkg::R2_W'(r_q);
  end

  // stage handshake
  logic v1_q, v2_q, v3_q;
  logic e1, e2, e3;

  assign e3 = !v3_q || out_ready_i;
  assign e2 = !v2_q || e3;
  assign e1 = !v1_q || e2;
  assign in_ready_o  = e1;
  assign out_valid_o = v3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (e1) v1_q <= in_valid_i;
      if (e2) v2_q <= v1_q;
      if (e3) v3_q <= v2_q;
    end
  end

  // stage 1: pixel offset, its squared length and dot with the light vector
  logic signed [DW-1:0]   dx, dy;
  logic [D2W-1:0]         d2_c, d2_q;
  logic signed [DOTW-1:0] dot_c, dot_q;

  assign dx    = $signed({2'b00, cx_q}) - $signed({pixel_x_i[COORD_BITS], pixel_x_i});
  assign dy    = $signed({2'b00, cy_q}) - $signed({pixel_y_i[COORD_BITS], pixel_y_i});
  assign d2_c  = D2W'(dx * dx) + D2W'(dy * dy);
  assign dot_c = DOTW'(dx) * DOTW'(vx_q) + DOTW'(dy) * DOTW'(vy_q);

  always_ff @(posedge clk_i) begin
    if (e1) begin
      d2_q  <= d2_c;
      dot_q <= dot_c;
    end
  end

  // stage 2: coverage, rim band and the two squared products
  logic [SW-1:0]            d20, r19;
  logic                     cov_c, rim_c, go_c;
  logic [DOTW-1:0]          absdot;
  logic [drls_pkg::NUM_W-1:0] mag;
  logic [2*drls_pkg::NUM_W-1:0] num_sq;
  logic                     cov_q, rim_q, go_q;
  logic [drls_pkg::DEN_W-1:0] den_q, num_q;

  assign d20    = SW'(d2_q) * SW'(20);
  assign r19    = SW'(r2_q) * SW'(19);
  assign cov_c  = SW'(d2_q) <= SW'(r2_q);
  assign rim_c  = cov_c && (d20 > r19);
  assign go_c   = rim_c && (l2_q != '0) && !dot_q[DOTW-1] && (dot_q != '0);
  assign absdot = dot_q[DOTW-1] ? DOTW'(-dot_q) : DOTW'(dot_q);
  assign mag    = drls_pkg::NUM_W'(absdot);
  assign num_sq = (2*drls_pkg::NUM_W)'(mag) * (2*drls_pkg::NUM_W)'(mag);

  always_ff @(posedge clk_i) begin
    if (e2) begin
      cov_q <= cov_c;
      rim_q <= rim_c;
      go_q  <= go_c;
      den_q <= drls_pkg::DEN_W'(d2_q) * drls_pkg::DEN_W'(l2_q);
      num_q <= num_sq[drls_pkg::DEN_W-1:0];
    end
  end

  // stage 3: scale the squared dot product by 255 squared
  drls_pkg::shade_t s3_q;

  always_ff @(posedge clk_i) begin
    if (e3) begin
      s3_q.covered <= cov_q;
      s3_q.rim     <= rim_q;
      s3_q.go      <= go_q;
      s3_q.den     <= den_q;
      s3_q.k       <= drls_pkg::CMP_W'(num_q) * drls_pkg::CMP_W'(drls_pkg::LEVEL_SCALE);
      s3_q.b       <= '0;
      s3_q.bden    <= '0;
      s3_q.b2den   <= '0;
    end
  end

  assign out_o = s3_q;

endmodule

// ----- hdl/drls_cell.sv -----
// drls_cell: one cell of the level chain, settles one brightness bit by a
// squared compare kept up with shifts and adds; uses drls_pkg
module drls_cell #(
  parameter int BIT = 7
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  output logic             ready_o,
  input  drls_pkg::shade_t data_i,
  output logic             valid_o,
  input  logic             ready_i,
  output drls_pkg::shade_t data_o
);

  logic             v_q, en;
  drls_pkg::shade_t s_q, s_d;
  logic [drls_pkg::CMP_W-1:0] t2den;
  logic             fits;

  assign en      = !v_q || ready_i;
  assign ready_o = en;
  assign valid_o = v_q;
  assign data_o  = s_q;

  // (b + 2^bit)^2 * den from b^2*den and b*den
  assign t2den = data_i.b2den
               + (drls_pkg::CMP_W'(data_i.bden) << (BIT + 1))
               + (drls_pkg::CMP_W'(data_i.den) << (2 * BIT));
  assign fits  = data_i.go && (t2den <= data_i.k);

  always_comb begin
    s_d = data_i;
    if (fits) begin
      s_d.b     = data_i.b | (drls_pkg::LEVEL_W'(1) << BIT);
      s_d.bden  = data_i.bden + (drls_pkg::BDEN_W'(data_i.den) << BIT);
      s_d.b2den = t2den;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (en) begin
      v_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) s_q <= s_d;
  end

endmodule

// ----- hdl/disc_rim_lambert_shader.sv -----
// disc_rim_lambert_shader: the result is registered through twelve register stages
// (three geometry stages, eight level cells, one output register); one pixel
// per cycle sustained while the output is ready, each cell settling one brightness bit.
// Reset clears all stage valid bits and loads the register reset values.
// Configuration writes are held in registers; the light vector and squared lengths are registered from them.
// Uses drls_pkg, drls_if, drls_front and drls_cell.
module disc_rim_lambert_shader #(
  parameter int COORD_BITS = drls_pkg::COORD_BITS_DEF
) (
  input  logic                                        clk_i,
  input  logic                                        rst_ni,
  input  logic                                        cfg_we_i,
  input  logic [drls_pkg::CFG_IDX_W-1:0]              cfg_idx_i,
  input  logic [drls_pkg::cfg_data_w(COORD_BITS)-1:0] cfg_data_i,
  drls_in_if.sink                                     pix_in,
  drls_out_if.source                                  shade_out
);

  localparam int NCELL = drls_pkg::LEVEL_W;

  logic             vld [NCELL+1];
  logic             rdy [NCELL+1];
  drls_pkg::shade_t dat [NCELL+1];

  // geometry front end
  drls_front #(.COORD_BITS(COORD_BITS)) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (pix_in.valid),
    .in_ready_o  (pix_in.ready),
    .pixel_x_i   (pix_in.pixel_x),
    .pixel_y_i   (pix_in.pixel_y),
    .out_valid_o (vld[0]),
    .out_ready_i (rdy[0]),
    .out_o       (dat[0])
  );

  // level chain, most significant bit first
  for (genvar i = 0; i < NCELL; i++) begin : g_cell
    drls_cell #(.BIT(NCELL - 1 - i)) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (vld[i]),
      .ready_o (rdy[i]),
      .data_i  (dat[i]),
      .valid_o (vld[i+1]),
      .ready_i (rdy[i+1]),
      .data_o  (dat[i+1])
    );
  end

  // output register
  logic                          out_v_q, out_en;
  logic                          cov_q, rim_q;
  logic [drls_pkg::LEVEL_W-1:0]  lvl_q;

  assign out_en     = !out_v_q || shade_out.ready;
  assign rdy[NCELL] = out_en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (out_en) begin
      out_v_q <= vld[NCELL];
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_en) begin
      cov_q <= dat[NCELL].covered;
      rim_q <= dat[NCELL].rim;
      lvl_q <= dat[NCELL].b;
    end
  end

  assign shade_out.valid      = out_v_q;
  assign shade_out.covered    = cov_q;
  assign shade_out.on_rim     = rim_q;
  assign shade_out.brightness = lvl_q;

  // rim pixels are always covered
  a_rim_covered: assert property (@(posedge clk_i) disable iff (!rst_ni)
    shade_out.valid |-> (shade_out.covered || !shade_out.on_rim))
    else $error("rim result not covered");

  // only rim pixels carry a grey level
  a_dark_off_rim: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (shade_out.valid && !shade_out.on_rim) |-> (shade_out.brightness == '0))
    else $error("brightness off the rim");

  // an empty output register lets requests in
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !shade_out.valid |-> pix_in.ready)
    else $error("input stalled with empty output");

endmodule
